// ===== rtl/core/height_to_color_ramp_assert.svh =====
// assertion macros for the color ramp block
// expect signals named clk and rst_n in the including module
`ifndef HEIGHT_TO_COLOR_RAMP_ASSERT_SVH
`define HEIGHT_TO_COLOR_RAMP_ASSERT_SVH

// condition holds in the same cycle
`define HTCR_ASSERT_SAME(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error(msg);

// condition holds in the following cycle
`define HTCR_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error(msg);

`endif

// ===== rtl/core/htcr_pkg.sv =====
// shared types and constants for the height to color ramp block
// no dependencies
`default_nettype none

package htcr_pkg;

  localparam int DEFAULT_MAX_POINTS = 32;

  localparam int HEIGHT_W = 16;
  localparam int CHAN_W   = 8;
  localparam int COLOR_W  = 3 * CHAN_W;
  localparam int ACC_W    = COLOR_W;
  localparam int CFG_IDX_W = 1;

  localparam logic [1:0] OP_START   = 2'd0;
  localparam logic [1:0] OP_APPEND  = 2'd1;
  localparam logic [1:0] OP_CONVERT = 2'd2;

  localparam logic [1:0] STATUS_IN_RANGE = 2'd0;
  localparam logic [1:0] STATUS_BELOW    = 2'd1;
  localparam logic [1:0] STATUS_EMPTY    = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_RANGE_MIN = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_RANGE_MAX = 1'b1;

  typedef enum logic [1:0] {
    ALU_NOP      = 2'd0,
    ALU_MUL_LOAD = 2'd1,
    ALU_MUL_ACC  = 2'd2,
    ALU_DIV_STEP = 2'd3
  } alu_op_t;

  typedef struct packed {
    alu_op_t             op;
    logic [CHAN_W-1:0]   coef;
    logic [HEIGHT_W-1:0] mul;
    logic [HEIGHT_W-1:0] divisor;
  } alu_req_t;

endpackage

`default_nettype wire

// ===== rtl/core/height_to_color_ramp.sv =====
// piecewise-linear height to color ramp over a loaded breakpoint table
// depends on htcr_pkg, htcr_alu and height_to_color_ramp_assert.svh
//
//  channel  dir  handshake          payload
//  in       in   in_valid/in_stall  opcode, bp_height, bp_red, bp_green, bp_blue
//  out      out  out_valid/out_stall red, green, blue, status
//  cfg      in   cfg_wr_en          cfg_index, cfg_wdata
//
// a convert scans table entries (one per cycle, one memory read port) and, when
// interpolating, runs per channel two multiply-accumulates, eight divide steps and
// a store, all on the one shared unit.
// reset is synchronous; the table needs no clearing, only the count is reset.
// a pending result in the output register does not block loads.
`default_nettype none
`include "height_to_color_ramp_assert.svh"

module height_to_color_ramp #(
  parameter int MAX_POINTS = htcr_pkg::DEFAULT_MAX_POINTS
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic [1:0]                        in_opcode,
  input  wire logic signed [htcr_pkg::HEIGHT_W-1:0] in_bp_height,
  input  wire logic [htcr_pkg::CHAN_W-1:0]       in_bp_red,
  input  wire logic [htcr_pkg::CHAN_W-1:0]       in_bp_green,
  input  wire logic [htcr_pkg::CHAN_W-1:0]       in_bp_blue,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic [htcr_pkg::CHAN_W-1:0]            out_red,
  output logic [htcr_pkg::CHAN_W-1:0]            out_green,
  output logic [htcr_pkg::CHAN_W-1:0]            out_blue,
  output logic [1:0]                             out_status,
  input  wire logic                              cfg_wr_en,
  input  wire logic [htcr_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [htcr_pkg::HEIGHT_W-1:0]     cfg_wdata
);
  import htcr_pkg::*;

  localparam int IDX_W   = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int CNT_W   = $clog2(MAX_POINTS + 1);
  localparam int ENTRY_W = HEIGHT_W + COLOR_W;

  typedef enum logic [6:0] {
    ST_IDLE   = 7'b0000001,
    ST_SEARCH = 7'b0000010,
    ST_MUL0   = 7'b0000100,
    ST_MUL1   = 7'b0001000,
    ST_DIV    = 7'b0010000,
    ST_STORE  = 7'b0100000,
    ST_DONE   = 7'b1000000
  } state_t;

  function automatic logic [CHAN_W-1:0] chan_sel(input logic [COLOR_W-1:0] c,
                                                 input logic [1:0] ch);
    logic [CHAN_W-1:0] v;
    v = '0;
    unique case (ch)
      2'd0:    v = c[3*CHAN_W-1:2*CHAN_W];
      2'd1:    v = c[2*CHAN_W-1:CHAN_W];
      2'd2:    v = c[CHAN_W-1:0];
      default: v = '0;
    endcase
    return v;
  endfunction

  // configuration
  logic signed [HEIGHT_W-1:0] range_min_r, range_max_r;

  // table
  logic [ENTRY_W-1:0] mem [MAX_POINTS];
  logic [ENTRY_W-1:0] mem_q_r;
  logic               wr_en;
  logic [IDX_W-1:0]   wr_addr;
  logic [IDX_W-1:0]   rd_addr;
  logic [ENTRY_W-1:0] wr_data;

  // control and datapath registers
  state_t                     state_r, state_nxt;
  logic [CNT_W-1:0]           count_r, count_nxt;
  logic signed [HEIGHT_W-1:0] last_h_r, last_h_nxt;
  logic signed [HEIGHT_W-1:0] hq_r, hq_nxt;
  logic [IDX_W-1:0]           cur_idx_r, cur_idx_nxt;
  logic signed [HEIGHT_W-1:0] hi1_r, hi1_nxt;
  logic [COLOR_W-1:0]         c0_r, c0_nxt;
  logic [COLOR_W-1:0]         c1_r, c1_nxt;
  logic [HEIGHT_W-1:0]        span_r, span_nxt;
  logic [HEIGHT_W-1:0]        d_r, d_nxt;
  logic [HEIGHT_W-1:0]        sd_r, sd_nxt;
  logic [1:0]                 ch_r, ch_nxt;
  logic [2:0]                 step_r, step_nxt;
  logic [COLOR_W-1:0]         res_rgb_r, res_rgb_nxt;
  logic [1:0]                 res_status_r, res_status_nxt;
  logic                       out_valid_r, out_valid_nxt;
  logic [COLOR_W-1:0]         out_rgb_r, out_rgb_nxt;
  logic [1:0]                 out_status_r, out_status_nxt;

  alu_req_t           alu_req;
  logic [ACC_W-1:0]   alu_acc;

  logic                       in_xfer;
  logic                       out_free;
  logic [CNT_W-1:0]           last_cnt;
  logic                       is_top;
  logic signed [HEIGHT_W-1:0] eff_h;
  logic signed [HEIGHT_W-1:0] mem_h;
  logic [COLOR_W-1:0]         mem_c;
  logic [HEIGHT_W:0]          span17;
  logic [HEIGHT_W:0]          d17;
  logic [COLOR_W-1:0]         in_color;

  htcr_alu u_alu (
    .clk (clk),
    .req (alu_req),
    .acc (alu_acc)
  );

  assign in_stall = (state_r != ST_IDLE);
  assign in_xfer  = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;
  assign in_color = {in_bp_red, in_bp_green, in_bp_blue};

  assign last_cnt = count_r - CNT_W'(1);
  assign is_top   = (CNT_W'(cur_idx_r) == last_cnt);
  assign mem_h    = mem_q_r[ENTRY_W-1:COLOR_W];
  assign mem_c    = mem_q_r[COLOR_W-1:0];

  // end entries take their heights from the range registers
  always_comb begin
    priority if (is_top) begin
      eff_h = range_max_r;
    end else if (cur_idx_r == '0) begin
      eff_h = range_min_r;
    end else begin
      eff_h = mem_h;
    end
  end

  assign span17 = {hi1_r[HEIGHT_W-1], hi1_r} - {eff_h[HEIGHT_W-1], eff_h};
  assign d17    = {hq_r[HEIGHT_W-1], hq_r} - {eff_h[HEIGHT_W-1], eff_h};

  // scan reads one entry ahead of the compare
  assign rd_addr = (state_r == ST_IDLE) ? last_cnt[IDX_W-1:0] : (cur_idx_r - IDX_W'(1));

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    last_h_nxt     = last_h_r;
    hq_nxt         = hq_r;
    cur_idx_nxt    = cur_idx_r;
    hi1_nxt        = hi1_r;
    c0_nxt         = c0_r;
    c1_nxt         = c1_r;
    span_nxt       = span_r;
    d_nxt          = d_r;
    sd_nxt         = sd_r;
    ch_nxt         = ch_r;
    step_nxt       = step_r;
    res_rgb_nxt    = res_rgb_r;
    res_status_nxt = res_status_r;
    wr_en          = 1'b0;
    wr_addr        = '0;
    wr_data        = {in_bp_height, in_color};
    alu_req.op      = ALU_NOP;
    alu_req.coef    = '0;
    alu_req.mul     = '0;
    alu_req.divisor = span_r;

    unique case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          if (in_opcode == OP_START || (in_opcode == OP_APPEND && count_r == '0)) begin
            wr_en      = 1'b1;
            wr_addr    = '0;
            count_nxt  = CNT_W'(1);
            last_h_nxt = in_bp_height;
          end else if (in_opcode == OP_APPEND) begin
            // full table and repeated height are dropped
            if (count_r < CNT_W'(MAX_POINTS) && last_h_r != in_bp_height) begin
              wr_en      = 1'b1;
              wr_addr    = count_r[IDX_W-1:0];
              count_nxt  = count_r + CNT_W'(1);
              last_h_nxt = in_bp_height;
            end
          end else if (in_opcode == OP_CONVERT) begin
            if (count_r == '0) begin
              res_rgb_nxt    = '0;
              res_status_nxt = STATUS_EMPTY;
              state_nxt      = ST_DONE;
            end else begin
              hq_nxt      = in_bp_height;
              cur_idx_nxt = last_cnt[IDX_W-1:0];
              state_nxt   = ST_SEARCH;
            end
          end
        end
      end
      ST_SEARCH: begin
        priority if (hq_r == eff_h) begin
          res_rgb_nxt    = mem_c;
          res_status_nxt = STATUS_IN_RANGE;
          state_nxt      = ST_DONE;
        end else if (hq_r > eff_h) begin
          res_status_nxt = STATUS_IN_RANGE;
          if (is_top) begin
            // above the top breakpoint
            res_rgb_nxt = mem_c;
            state_nxt   = ST_DONE;
          end else begin
            span_nxt  = span17[HEIGHT_W-1:0];
            d_nxt     = d17[HEIGHT_W-1:0];
            sd_nxt    = span17[HEIGHT_W-1:0] - d17[HEIGHT_W-1:0];
            c0_nxt    = mem_c;
            ch_nxt    = 2'd0;
            state_nxt = ST_MUL0;
          end
        end else if (cur_idx_r == '0) begin
          res_rgb_nxt    = '0;
          res_status_nxt = STATUS_BELOW;
          state_nxt      = ST_DONE;
        end else begin
          hi1_nxt     = eff_h;
          c1_nxt      = mem_c;
          cur_idx_nxt = cur_idx_r - IDX_W'(1);
        end
      end
      ST_MUL0: begin
        alu_req.op   = ALU_MUL_LOAD;
        alu_req.coef = chan_sel(c0_r, ch_r);
        alu_req.mul  = sd_r;
        state_nxt    = ST_MUL1;
      end
      ST_MUL1: begin
        alu_req.op   = ALU_MUL_ACC;
        alu_req.coef = chan_sel(c1_r, ch_r);
        alu_req.mul  = d_r;
        step_nxt     = '0;
        state_nxt    = ST_DIV;
      end
      ST_DIV: begin
        alu_req.op = ALU_DIV_STEP;
        step_nxt   = step_r + 3'd1;
        if (step_r == 3'd7) begin
          state_nxt = ST_STORE;
        end
      end
      ST_STORE: begin
        unique case (ch_r)
          2'd0:    res_rgb_nxt[3*CHAN_W-1:2*CHAN_W] = alu_acc[CHAN_W-1:0];
          2'd1:    res_rgb_nxt[2*CHAN_W-1:CHAN_W]   = alu_acc[CHAN_W-1:0];
          2'd2:    res_rgb_nxt[CHAN_W-1:0]          = alu_acc[CHAN_W-1:0];
          default: res_rgb_nxt = res_rgb_r;
        endcase
        if (ch_r == 2'd2) begin
          state_nxt = ST_DONE;
        end else begin
          ch_nxt    = ch_r + 2'd1;
          state_nxt = ST_MUL0;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // output register
  always_comb begin
    out_valid_nxt  = out_valid_r && out_stall;
    out_rgb_nxt    = out_rgb_r;
    out_status_nxt = out_status_r;
    if (state_r == ST_DONE && out_free) begin
      out_valid_nxt  = 1'b1;
      out_rgb_nxt    = res_rgb_r;
      out_status_nxt = res_status_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
      range_min_r <= '0;
      range_max_r <= HEIGHT_W'(255);
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        unique case (cfg_index)
          CFG_RANGE_MIN: range_min_r <= cfg_wdata;
          CFG_RANGE_MAX: range_max_r <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    last_h_r     <= last_h_nxt;
    hq_r         <= hq_nxt;
    cur_idx_r    <= cur_idx_nxt;
    hi1_r        <= hi1_nxt;
    c0_r         <= c0_nxt;
    c1_r         <= c1_nxt;
    span_r       <= span_nxt;
    d_r          <= d_nxt;
    sd_r         <= sd_nxt;
    ch_r         <= ch_nxt;
    step_r       <= step_nxt;
    res_rgb_r    <= res_rgb_nxt;
    res_status_r <= res_status_nxt;
    out_rgb_r    <= out_rgb_nxt;
    out_status_r <= out_status_nxt;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    mem_q_r <= mem[rd_addr];
  end

  assign out_valid  = out_valid_r;
  assign out_red    = out_rgb_r[3*CHAN_W-1:2*CHAN_W];
  assign out_green  = out_rgb_r[2*CHAN_W-1:CHAN_W];
  assign out_blue   = out_rgb_r[CHAN_W-1:0];
  assign out_status = out_status_r;

  `HTCR_ASSERT_SAME(a_div_nonzero, state_r == ST_DIV, span_r != '0,
                    "divide step with zero span")
  `HTCR_ASSERT_SAME(a_inside_segment, state_r == ST_MUL0, d_r != '0 && d_r < span_r,
                    "interpolation point outside its segment")
  `HTCR_ASSERT_NEXT(a_start_count, in_xfer && in_opcode == OP_START, count_r == CNT_W'(1),
                    "new table did not leave one breakpoint")
  `HTCR_ASSERT_NEXT(a_result_out, state_r == ST_DONE && out_free,
                    out_valid_r && state_r == ST_IDLE,
                    "finished result not moved to the output register")

endmodule

`default_nettype wire

// ===== rtl/core/htcr_alu.sv =====
// shared multiply-accumulate and restoring divide-step unit
// depends on htcr_pkg
`default_nettype none

module htcr_alu (
  input  wire logic                    clk,
  input  wire htcr_pkg::alu_req_t      req,
  output logic [htcr_pkg::ACC_W-1:0]   acc
);
  import htcr_pkg::*;

  logic [ACC_W-1:0]    acc_r;
  logic [ACC_W-1:0]    acc_nxt;
  logic [ACC_W-1:0]    prod;
  logic [HEIGHT_W:0]   trial;
  logic [HEIGHT_W:0]   diff;
  logic                qbit;
  logic [HEIGHT_W-1:0] rem;

  assign prod = ACC_W'({{(ACC_W-CHAN_W){1'b0}}, req.coef} *
                       {{(ACC_W-HEIGHT_W){1'b0}}, req.mul});

  // partial remainder sits in the upper bits, quotient shifts in at the bottom
  assign trial = {acc_r[ACC_W-1:CHAN_W], acc_r[CHAN_W-1]};
  assign diff  = trial - {1'b0, req.divisor};
  assign qbit  = (trial >= {1'b0, req.divisor});
  assign rem   = qbit ? diff[HEIGHT_W-1:0] : trial[HEIGHT_W-1:0];

  always_comb begin
    unique case (req.op)
      ALU_NOP:      acc_nxt = acc_r;
      ALU_MUL_LOAD: acc_nxt = prod;
      ALU_MUL_ACC:  acc_nxt = acc_r + prod;
      ALU_DIV_STEP: acc_nxt = {rem, acc_r[CHAN_W-2:0], qbit};
      default:      acc_nxt = acc_r;
    endcase
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
  end

  assign acc = acc_r;

endmodule

`default_nettype wire
